FILE: sv/floyd_steinberg_dither_1bit_top_macros.svh
// Assertion macros used by the dither input stage.
`ifndef FLOYD_STEINBERG_DITHER_1BIT_TOP_MACROS_SVH
`define FLOYD_STEINBERG_DITHER_1BIT_TOP_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define FSD_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FSD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/fsd_pkg.sv
// Shared types, constants and helpers for the 1-bit error-diffusion dither.
`default_nettype none

package fsd_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int ERR_W     = 10;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam int IMG_W_W   = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

    localparam logic [IMG_W_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [ROW_W-1:0]   RESET_HEIGHT = 16'd480;

    localparam logic signed [11:0] PIX_MIN   = 12'sd0;
    localparam logic signed [11:0] PIX_MAX   = 12'sd255;
    localparam logic signed [8:0]  WHITE_VAL = 9'sd255;
    localparam logic signed [10:0] WT_RIGHT  = 11'sd7;
    localparam logic signed [10:0] WT_DOWN_L = 11'sd3;
    localparam logic signed [10:0] WT_DOWN   = 11'sd5;

    typedef logic [COL_W-1:0]        col_t;
    typedef logic [ROW_W-1:0]        row_t;
    typedef logic signed [ERR_W-1:0] err_t;

    // frame geometry plus a restart pulse on a width or height register write
    typedef struct packed {
        logic restart;
        col_t last_col;
        row_t last_row;
    } fsd_geom_t;

    // pixel held in the input stage, with its line-buffer term
    typedef struct packed {
        logic [7:0] gray;
        logic [7:0] alpha;
        col_t       col;
        logic       first_row;
        logic       last_col;
        logic       last_row;
        err_t       below;
    } fsd_item_t;

    // line-buffer updates produced by one processed pixel
    typedef struct packed {
        logic main_en;
        col_t main_addr;
        err_t main_data;
        logic tail_en;
        col_t tail_addr;
        err_t tail_data;
    } fsd_wb_t;

    // divide by 16, truncating toward zero
    function automatic err_t div16_tz(input logic signed [10:0] v);
        logic signed [11:0] biased;
        logic signed [11:0] shifted;
        biased  = 12'(v) + (v[10] ? 12'sd15 : 12'sd0);
        shifted = biased >>> 4;
        return shifted[ERR_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/fsd_cfg.sv
// Geometry registers: image width and height, clamped to legal ranges.
`default_nettype none

module fsd_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [fsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fsd_pkg::CFG_DAT_W-1:0]   cfg_wdata,
    output fsd_pkg::fsd_geom_t                   geom
);

    fsd_pkg::col_t last_col_reg, last_col_next;
    fsd_pkg::row_t last_row_reg, last_row_next;
    logic          restart_next;
    logic [fsd_pkg::IMG_W_W-1:0] w_in;
    logic [fsd_pkg::ROW_W-1:0]   h_in;
    logic                        wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign w_in      = cfg_wdata[fsd_pkg::IMG_W_W-1:0];
    assign h_in      = cfg_wdata[fsd_pkg::ROW_W-1:0];

    always_comb begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        restart_next  = 1'b0;
        if (wr) begin
            unique case (cfg_index)
                fsd_pkg::REG_IMAGE_WIDTH: begin
                    restart_next = 1'b1;
                    if (w_in == '0) begin
                        last_col_next = '0;
                    end else if (32'(w_in) > fsd_pkg::MAX_WIDTH) begin
                        last_col_next = fsd_pkg::COL_W'(fsd_pkg::MAX_WIDTH - 1);
                    end else begin
                        last_col_next = fsd_pkg::COL_W'(w_in - 1'b1);
                    end
                end
                fsd_pkg::REG_IMAGE_HEIGHT: begin
                    restart_next  = 1'b1;
                    last_row_next = (h_in == '0) ? '0 : h_in - 1'b1;
                end
                default: begin
                    restart_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg <= fsd_pkg::COL_W'(fsd_pkg::RESET_WIDTH - 1'b1);
            last_row_reg <= fsd_pkg::RESET_HEIGHT - 1'b1;
        end else begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
        end
    end

    // restart goes out combinationally so the frame state clears on the write edge
    assign geom.restart  = restart_next;
    assign geom.last_col = last_col_reg;
    assign geom.last_row = last_row_reg;

endmodule

`default_nettype wire

FILE: sv/fsd_scan.sv
// Input stage: raster counters, next-row error line buffer and bypass.
`default_nettype none

module fsd_scan (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire fsd_pkg::fsd_geom_t   geom,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           in_gray,
    input  wire logic [7:0]           in_alpha,
    output logic                      item_valid,
    input  wire logic                 item_ready,
    output fsd_pkg::fsd_item_t        item,
    input  wire fsd_pkg::fsd_wb_t     wb
);

`include "floyd_steinberg_dither_1bit_top_macros.svh"

    fsd_pkg::err_t line_mem [fsd_pkg::MAX_WIDTH];

    fsd_pkg::col_t col_reg, col_next;
    fsd_pkg::row_t row_reg, row_next;
    logic          p1_valid_reg, p1_valid_next;
    logic          pend_valid_reg;
    fsd_pkg::col_t pend_addr_reg;
    fsd_pkg::err_t pend_data_reg;

    logic [7:0]    gray_reg, alpha_reg;
    fsd_pkg::col_t icol_reg;
    logic          first_row_reg, last_col_reg, last_row_reg;
    fsd_pkg::err_t rd_raw_reg;
    logic          fwd_hit_reg;
    fsd_pkg::err_t fwd_data_reg;

    logic          accept;
    logic          at_last_col, at_last_row;
    logic          wr_en;
    fsd_pkg::col_t wr_addr;
    fsd_pkg::err_t wr_data;
    logic          fwd_hit;
    fsd_pkg::err_t fwd_data;

    assign in_ready    = !p1_valid_reg || item_ready;
    assign accept      = in_valid && in_ready;
    assign at_last_col = (col_reg == geom.last_col);
    assign at_last_row = (row_reg == geom.last_row);

    // raster position
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (geom.restart) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (at_last_col) begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (accept) begin
            p1_valid_next = 1'b1;
        end else if (item_ready) begin
            p1_valid_next = 1'b0;
        end
    end

    // one write port: the end-of-row tail is registered and written
    // in the cycle after, as the first pixel of a row writes nothing
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pend_addr_reg;
        wr_data = pend_data_reg;
        if (wb.main_en) begin
            wr_en   = 1'b1;
            wr_addr = wb.main_addr;
            wr_data = wb.main_data;
        end else if (pend_valid_reg) begin
            wr_en = 1'b1;
        end
    end

    // bypass for values not yet in the array when the read is issued
    always_comb begin
        fwd_hit  = 1'b0;
        fwd_data = wb.main_data;
        priority if (wb.main_en && wb.main_addr == col_reg) begin
            fwd_hit  = 1'b1;
            fwd_data = wb.main_data;
        end else if (wb.tail_en && wb.tail_addr == col_reg) begin
            fwd_hit  = 1'b1;
            fwd_data = wb.tail_data;
        end else if (pend_valid_reg && pend_addr_reg == col_reg) begin
            fwd_hit  = 1'b1;
            fwd_data = pend_data_reg;
        end else begin
            fwd_hit = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        if (accept) begin
            rd_raw_reg <= line_mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            p1_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            p1_valid_reg   <= p1_valid_next;
            pend_valid_reg <= wb.tail_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (wb.tail_en) begin
            pend_addr_reg <= wb.tail_addr;
            pend_data_reg <= wb.tail_data;
        end
        if (accept) begin
            gray_reg      <= in_gray;
            alpha_reg     <= in_alpha;
            icol_reg      <= col_reg;
            first_row_reg <= (row_reg == '0);
            last_col_reg  <= at_last_col;
            last_row_reg  <= at_last_row;
            fwd_hit_reg   <= fwd_hit;
            fwd_data_reg  <= fwd_data;
        end
    end

    assign item_valid     = p1_valid_reg;
    assign item.gray      = gray_reg;
    assign item.alpha     = alpha_reg;
    assign item.col       = icol_reg;
    assign item.first_row = first_row_reg;
    assign item.last_col  = last_col_reg;
    assign item.last_row  = last_row_reg;
    assign item.below     = fwd_hit_reg ? fwd_data_reg : rd_raw_reg;

    `FSD_ASSERT_ALWAYS(a_wr_port_free, aclk, aresetn, !(wb.main_en && pend_valid_reg), "line buffer write collision")
    `FSD_ASSERT_ALWAYS(a_col_in_row, aclk, aresetn, col_reg <= geom.last_col, "column past row end")
    `FSD_ASSERT_ALWAYS(a_main_left, aclk, aresetn, !wb.main_en || wb.main_addr < geom.last_col, "write past row end")
    `FSD_ASSERT_NEXT(a_frame_wrap, aclk, aresetn, accept && at_last_col && at_last_row, col_reg == '0 && row_reg == '0, "frame did not wrap")

endmodule

`default_nettype wire

FILE: sv/fsd_diffuse.sv
// Processing stage: threshold, error split and result register.
`default_nettype none

module fsd_diffuse (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire fsd_pkg::fsd_geom_t   geom,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire fsd_pkg::fsd_item_t   item,
    output fsd_pkg::fsd_wb_t          wb,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      out_white,
    output logic [7:0]                out_alpha,
    output logic                      out_last
);

    fsd_pkg::err_t right_carry_reg,   right_carry_next;
    fsd_pkg::err_t below_pending_reg, below_pending_next;
    fsd_pkg::err_t below_diag_reg,    below_diag_next;
    logic          out_valid_reg,     out_valid_next;
    logic          white_reg;
    logic [7:0]    alpha_reg;
    logic          last_reg;

    logic               fire;
    fsd_pkg::err_t      below_used;
    logic signed [10:0] acc;
    logic signed [11:0] corr_raw;
    logic [7:0]         corr;
    logic               white;
    logic signed [8:0]  err;
    logic signed [10:0] err_x;
    fsd_pkg::err_t      e7, e5, e3, e1;

    assign item_ready = !out_valid_reg || out_ready;
    assign fire       = item_valid && item_ready;

    always_comb begin
        below_used = item.first_row ? '0 : $signed(item.below);
        acc        = 11'(right_carry_reg) + 11'(below_used);
        corr_raw   = $signed({4'b0000, item.gray}) + 12'(acc);
        priority if (corr_raw < fsd_pkg::PIX_MIN) begin
            corr = '0;
        end else if (corr_raw > fsd_pkg::PIX_MAX) begin
            corr = 8'hFF;
        end else begin
            corr = corr_raw[7:0];
        end
        white = corr[7];
        err   = white ? $signed({1'b0, corr}) - fsd_pkg::WHITE_VAL : $signed({1'b0, corr});
        err_x = 11'(err);
        e7    = fsd_pkg::div16_tz(err_x * fsd_pkg::WT_RIGHT);
        e5    = fsd_pkg::div16_tz(err_x * fsd_pkg::WT_DOWN);
        e3    = fsd_pkg::div16_tz(err_x * fsd_pkg::WT_DOWN_L);
        e1    = fsd_pkg::div16_tz(err_x);
    end

    // lower-left term completes the entry one column back; at row end the
    // lower term goes to this column as well
    always_comb begin
        wb.main_en   = fire && !item.last_row && (item.col != '0);
        wb.main_addr = item.col - 1'b1;
        wb.main_data = below_pending_reg + e3;
        wb.tail_en   = fire && !item.last_row && item.last_col;
        wb.tail_addr = item.col;
        wb.tail_data = below_diag_reg + e5;
    end

    always_comb begin
        right_carry_next   = right_carry_reg;
        below_pending_next = below_pending_reg;
        below_diag_next    = below_diag_reg;
        if (geom.restart) begin
            right_carry_next   = '0;
            below_pending_next = '0;
            below_diag_next    = '0;
        end else if (fire) begin
            if (item.last_col) begin
                right_carry_next   = '0;
                below_pending_next = '0;
                below_diag_next    = '0;
            end else begin
                right_carry_next = e7;
                if (!item.last_row) begin
                    below_pending_next = below_diag_reg + e5;
                    below_diag_next    = e1;
                end
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_carry_reg   <= '0;
            below_pending_reg <= '0;
            below_diag_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            right_carry_reg   <= right_carry_next;
            below_pending_reg <= below_pending_next;
            below_diag_reg    <= below_diag_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            white_reg <= white;
            alpha_reg <= item.alpha;
            last_reg  <= item.last_col && item.last_row;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_white = white_reg;
    assign out_alpha = alpha_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

FILE: sv/floyd_steinberg_dither_1bit_top.sv
// Top level of the 1-bit Floyd-Steinberg dither for gray+alpha pixel streams.
`default_nettype none

// Gray+alpha pixels enter in raster order on the s_ stream, one per transfer,
// and every pixel yields exactly one result transfer on the m_ stream: a
// black/white bit, the alpha passed through, and tlast on the final pixel of
// the frame. The block sustains one pixel per clock while m_tready is high;
// a pixel passes the input register, then the result register, and the rate
// is set by the error loop in the processing stage, where the right-hand
// carry of one pixel feeds the next. Quantization error for the following
// row lives in a MAX_WIDTH-entry line buffer with one write port and one
// registered read per pixel; it needs no clearing pass after reset, since the
// first row of each frame ignores it. Writes to image_width (index 0) or
// image_height (index 1) restart the frame at row 0, column 0 and must be
// issued only while the pipeline is empty; a width of 0 acts as 1, widths
// above MAX_WIDTH act as MAX_WIDTH, a height of 0 acts as 1, and writes to
// other indexes are ignored. After reset the geometry is 640 x 480.
module floyd_steinberg_dither_1bit_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [fsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fsd_pkg::CFG_DAT_W-1:0]   cfg_wdata,
    // pixel input
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [15:0]                     s_tdata,   // [7:0] gray_in, [15:8] alpha_in
    // dithered output
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [15:0]                          m_tdata,   // [0] pixel_white, [8:1] alpha_out
    output logic                                 m_tlast    // frame_last
);

    fsd_pkg::fsd_geom_t geom;
    fsd_pkg::fsd_item_t item;
    fsd_pkg::fsd_wb_t   wb;
    logic               item_valid;
    logic               item_ready;
    logic               out_white;
    logic [7:0]         out_alpha;

    fsd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .geom      (geom)
    );

    // counters, line buffer and input register
    fsd_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .geom       (geom),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_gray    (s_tdata[7:0]),
        .in_alpha   (s_tdata[15:8]),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .wb         (wb)
    );

    // threshold, error spreading and result register
    fsd_diffuse u_diffuse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .geom       (geom),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .wb         (wb),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_white  (out_white),
        .out_alpha  (out_alpha),
        .out_last   (m_tlast)
    );

    assign m_tdata = {7'b0000000, out_alpha, out_white};

endmodule

`default_nettype wire
